// ===== design/dzcf_pkg.sv =====
// dead-zone crop follower: shared types and constants
// no dependencies; imported by the config block and the top level
`default_nettype none

package dzcf_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CROP_WIDTH     = 3'd0,
		CFG_CROP_HEIGHT    = 3'd1,
		CFG_DEAD_ZONE_FRAC = 3'd2,
		CFG_MOVE_THRESHOLD = 3'd3,
		CFG_CLAMP_CENTER   = 3'd4
	} cfg_idx_t;

	// fractions used for reset values, in percent
	localparam int DEAD_ZONE_PCT = 55;
	localparam int THRESHOLD_PCT = 1;
	localparam int PCT_SCALE     = 100;

endpackage

`default_nettype wire

// ===== design/dzcf_cfg.sv =====
// dead-zone crop follower: configuration registers and per-axis derived values
// uses dzcf_pkg for register index codes
`default_nettype none

module dzcf_cfg #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [dzcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FRAC_BITS:0]           cfg_data,
	output logic      [FRAC_BITS:0]           hx,
	output logic      [FRAC_BITS:0]           hy,
	output logic      [FRAC_BITS:0]           halfx,
	output logic      [FRAC_BITS:0]           halfy,
	output logic      [FRAC_BITS:0]           hix,
	output logic      [FRAC_BITS:0]           hiy,
	output logic      [FRAC_BITS:0]           cmaxx,
	output logic      [FRAC_BITS:0]           cmaxy,
	output logic      [2*FRAC_BITS+1:0]       thr_sq,
	output logic                              clamp_en
);
	import dzcf_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
	localparam int DZ_RST  = ((1 << FRAC_BITS) * DEAD_ZONE_PCT + PCT_SCALE / 2) / PCT_SCALE;
	localparam int THR_RST = ((1 << FRAC_BITS) * THRESHOLD_PCT + PCT_SCALE / 2) / PCT_SCALE;

	logic [W-1:0] cw_q, ch_q, dz_q, thr_q;
	logic         clamp_q;
	logic [W-1:0] data_sat;
	logic [2*W-1:0] prod_x, prod_y;
	logic [W-1:0]   hx_q, hy_q, halfx_q, halfy_q, hix_q, hiy_q, cmaxx_q, cmaxy_q;
	logic [2*W-1:0] thr_sq_q;

	assign data_sat = (cfg_data > ONE) ? ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q    <= ONE;
			ch_q    <= ONE;
			dz_q    <= W'(DZ_RST);
			thr_q   <= W'(THR_RST);
			clamp_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CROP_WIDTH:     cw_q    <= data_sat;
				CFG_CROP_HEIGHT:    ch_q    <= data_sat;
				CFG_DEAD_ZONE_FRAC: dz_q    <= data_sat;
				CFG_MOVE_THRESHOLD: thr_q   <= data_sat;
				CFG_CLAMP_CENTER:   clamp_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign prod_x = dz_q * cw_q;
	assign prod_y = dz_q * ch_q;

	// derived values follow the registers in the next cycle
	always_ff @(posedge clk) begin
		hx_q     <= prod_x[2*W-1:W];
		hy_q     <= prod_y[2*W-1:W];
		halfx_q  <= cw_q >> 1;
		halfy_q  <= ch_q >> 1;
		hix_q    <= ONE - (cw_q - (cw_q >> 1));
		hiy_q    <= ONE - (ch_q - (ch_q >> 1));
		cmaxx_q  <= ONE - cw_q;
		cmaxy_q  <= ONE - ch_q;
		thr_sq_q <= thr_q * thr_q;
	end

	assign hx       = hx_q;
	assign hy       = hy_q;
	assign halfx    = halfx_q;
	assign halfy    = halfy_q;
	assign hix      = hix_q;
	assign hiy      = hiy_q;
	assign cmaxx    = cmaxx_q;
	assign cmaxy    = cmaxy_q;
	assign thr_sq   = thr_sq_q;
	assign clamp_en = clamp_q;

endmodule

`default_nettype wire

// ===== design/dzcf_axis.sv =====
// dead-zone crop follower: one axis of the follow step and the crop corner
// combinational; no package dependency
`default_nettype none

module dzcf_axis #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               tick,
	input  wire logic               clamp_en,
	input  wire logic [FRAC_BITS:0] ctr,
	input  wire logic [FRAC_BITS:0] pos,
	input  wire logic [FRAC_BITS:0] h,
	input  wire logic [FRAC_BITS:0] half,
	input  wire logic [FRAC_BITS:0] hi,
	input  wire logic [FRAC_BITS:0] cmax,
	output logic      [FRAC_BITS:0] ctr_next,
	output logic      [FRAC_BITS:0] corner
);
	localparam int W  = FRAC_BITS + 1;
	localparam int SW = W + 2;
	localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

	logic signed [SW-1:0] c_s, p_s, h_s, dz_lo, dz_hi, c1, c2, c3, half_s, hi_s, cmax_s, d;
	logic        [W-1:0]  follow;

	always_comb begin
		c_s    = $signed(SW'(ctr));
		p_s    = $signed(SW'(pos));
		h_s    = $signed(SW'(h));
		half_s = $signed(SW'(half));
		hi_s   = $signed(SW'(hi));
		cmax_s = $signed(SW'(cmax));
		dz_lo  = p_s - h_s;
		dz_hi  = p_s + h_s;

		// dead zone window around the cursor
		if (c_s < dz_lo)
			c1 = dz_lo;
		else if (c_s > dz_hi)
			c1 = dz_hi;
		else
			c1 = c_s;

		// frame bounds
		if (c1 < 0)
			c2 = '0;
		else if (c1 > ONE_S)
			c2 = ONE_S;
		else
			c2 = c1;

		// pan range
		if (clamp_en && c2 < half_s)
			c3 = half_s;
		else if (clamp_en && c2 > hi_s)
			c3 = hi_s;
		else
			c3 = c2;

		follow   = c3[W-1:0];
		ctr_next = tick ? follow : pos;

		d = $signed(SW'(ctr_next)) - half_s;
		if (d < 0)
			corner = '0;
		else if (d > cmax_s)
			corner = cmax;
		else
			corner = d[W-1:0];
	end

endmodule

`default_nettype wire

// ===== design/dead_zone_crop_follower_top.sv =====
// dead-zone crop follower: top level with input stage, centre state and result stage
// uses dzcf_pkg, dzcf_cfg and dzcf_axis
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pos_x, pos_y; tuser: mode
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: center_x, center_y, crop_left,
//                                                crop_top; tuser: emit
//  cfg       in   cfg_we                         cfg_index, cfg_data
//
// one transfer per cycle sustained while results are taken; both stages are registered
// the follow step and the distance square compare sit between the input stage
// and the result stage, with the centre state updated as the result is loaded
// a stalled result holds the result stage, the input stage still takes one item if empty
// reset puts the centre and last emitted point at mid-frame and loads the register defaults
`default_nettype none

module dead_zone_crop_follower_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     s_axis_tvalid,
	output logic                                          s_axis_tready,
	// pos_x, pos_y
	input  wire logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0]     s_axis_tdata,
	// mode
	input  wire logic                                     s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  wire logic                                     m_axis_tready,
	// center_x, center_y, crop_left, crop_top
	output logic      [((4*(FRAC_BITS+1)+7)/8)*8-1:0]     m_axis_tdata,
	// emit
	output logic                                          m_axis_tuser,
	input  wire logic                                     cfg_we,
	input  wire logic [dzcf_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [FRAC_BITS:0]                       cfg_data
);
	localparam int W     = FRAC_BITS + 1;
	localparam int OUT_W = ((4*W+7)/8)*8;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
	localparam logic [W-1:0] MID = W'(1) << (FRAC_BITS - 1);

	logic [W-1:0]   hx, hy, halfx, halfy, hix, hiy, cmaxx, cmaxy;
	logic [2*W-1:0] thr_sq;
	logic           clamp_en;

	dzcf_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.hx       (hx),
		.hy       (hy),
		.halfx    (halfx),
		.halfy    (halfy),
		.hix      (hix),
		.hiy      (hiy),
		.cmaxx    (cmaxx),
		.cmaxy    (cmaxy),
		.thr_sq   (thr_sq),
		.clamp_en (clamp_en)
	);

	// input stage
	logic         v_s1, mode_s1;
	logic [W-1:0] px_s1, py_s1, px_in, py_in;
	logic         adv;

	assign px_in = (s_axis_tdata[W-1:0] > ONE) ? ONE : s_axis_tdata[W-1:0];
	assign py_in = (s_axis_tdata[2*W-1:W] > ONE) ? ONE : s_axis_tdata[2*W-1:W];

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tuser;
			px_s1   <= px_in;
			py_s1   <= py_in;
		end
	end

	// follow step
	logic [W-1:0] ctr_x_q, ctr_y_q, last_x_q, last_y_q;
	logic [W-1:0] cx_n, cy_n, left_n, top_n;

	dzcf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
		.tick    (mode_s1),
		.clamp_en(clamp_en),
		.ctr     (ctr_x_q),
		.pos     (px_s1),
		.h       (hx),
		.half    (halfx),
		.hi      (hix),
		.cmax    (cmaxx),
		.ctr_next(cx_n),
		.corner  (left_n)
	);

	dzcf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
		.tick    (mode_s1),
		.clamp_en(clamp_en),
		.ctr     (ctr_y_q),
		.pos     (py_s1),
		.h       (hy),
		.half    (halfy),
		.hi      (hiy),
		.cmax    (cmaxy),
		.ctr_next(cy_n),
		.corner  (top_n)
	);

	// squared move since last emission
	logic signed [W:0]     dx, dy;
	logic signed [2*W+1:0] sqx, sqy;
	logic        [2*W:0]   d2;
	logic                  emit_n;
	logic                  step;

	assign dx     = $signed({1'b0, cx_n}) - $signed({1'b0, last_x_q});
	assign dy     = $signed({1'b0, cy_n}) - $signed({1'b0, last_y_q});
	assign sqx    = dx * dx;
	assign sqy    = dy * dy;
	assign d2     = {1'b0, sqx[2*W-1:0]} + {1'b0, sqy[2*W-1:0]};
	assign emit_n = !mode_s1 || (d2 > {1'b0, thr_sq});
	assign step   = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q  <= MID;
			ctr_y_q  <= MID;
			last_x_q <= MID;
			last_y_q <= MID;
		end else if (step) begin
			ctr_x_q <= cx_n;
			ctr_y_q <= cy_n;
			if (emit_n) begin
				last_x_q <= cx_n;
				last_y_q <= cy_n;
			end
		end
	end

	// result stage
	logic         v_s2, emit_s2;
	logic [W-1:0] cx_s2, cy_s2, left_s2, top_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cx_s2   <= cx_n;
			cy_s2   <= cy_n;
			left_s2 <= left_n;
			top_s2  <= top_n;
			emit_s2 <= emit_n;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = OUT_W'({top_s2, left_s2, cy_s2, cx_s2});
	assign m_axis_tuser  = emit_s2;

	// a free input stage always takes a transfer
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// the centre never leaves the frame
	a_ctr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_x_q <= ONE && ctr_y_q <= ONE)
		else $error("centre outside frame");

	// an emission moves the last emitted point onto the centre
	a_emit_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit_n |=> last_x_q == ctr_x_q && last_y_q == ctr_y_q)
		else $error("last point not updated on emission");

	// the presented centre matches the state it was taken from
	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> cx_s2 == ctr_x_q && cy_s2 == ctr_y_q)
		else $error("result centre differs from state");

endmodule

`default_nettype wire

// ===== tb/dead_zone_crop_follower_top_test.sv =====
`timescale 1ns / 1ps
// testbench for the dead-zone crop follower: random and directed position transfers
// checked against a local model of the follow step; needs dzcf_pkg and dead_zone_crop_follower_top
module dead_zone_crop_follower_top_test;
	import dzcf_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int VW = FRAC_BITS + 1;
	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam int VMAX = 2**VW - 1;
	localparam int S_W = ((2*VW+7)/8)*8;
	localparam int M_W = ((4*VW+7)/8)*8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_PHASES = 12;
	localparam int PHASE_ITEMS = 90;
	localparam int HOLD_CYCLES = 300;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef logic [VW-1:0] val_t;
	typedef struct packed { logic mode; val_t px; val_t py; } cursor_t;
	typedef struct packed { val_t cx; val_t cy; val_t left; val_t top; logic emit; } crop_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_W-1:0] s_axis_tdata = '0; // pos_x, pos_y
	logic s_axis_tuser = 1'b0; // mode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_W-1:0] m_axis_tdata; // center_x, center_y, crop_left, crop_top
	logic m_axis_tuser; // emit
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FRAC_BITS:0] cfg_data = '0;

	dead_zone_crop_follower_top #(.FRAC_BITS(FRAC_BITS)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// follower model state and register copies
	longint cur_cx = ONE / 2, cur_cy = ONE / 2, emit_x = ONE / 2, emit_y = ONE / 2;
	val_t crop_w = val_t'(ONE), crop_h = val_t'(ONE), dz_frac = 36045, thresh = 655;
	logic clamp_on = 1'b1;

	cursor_t cursor_q[$];
	crop_t crop_q[$];
	int issued = 0, accepted = 0, errors = 0, cycle_cnt = 0;
	int send_idle = 0, rx_stall = 0;
	int hold_left = 0;
	logic hold_req = 1'b0;
	logic s_fire = 1'b0;
	longint walk_x = ONE / 2, walk_y = ONE / 2;

	function automatic longint sat(val_t v);
		return (v > ONE) ? ONE : longint'(v);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint track_axis(longint c, longint p, longint size);
		longint h, lo;
		h = (sat(dz_frac) * size) >> (FRAC_BITS + 1);
		c = clip(c, p - h, p + h);
		c = clip(c, 0, ONE);
		if (clamp_on) begin
			lo = size >> 1;
			c = clip(c, lo, ONE - (size - lo));
		end
		return c;
	endfunction

	function automatic crop_t crop_follow(cursor_t cur);
		longint px, py, cw, ch, dx, dy;
		crop_t r;
		px = sat(cur.px);
		py = sat(cur.py);
		cw = sat(crop_w);
		ch = sat(crop_h);
		r.emit = 1'b0;
		if (cur.mode == MODE_LOAD) begin
			cur_cx = px;
			cur_cy = py;
			emit_x = px;
			emit_y = py;
			r.emit = 1'b1;
		end else begin
			cur_cx = track_axis(cur_cx, px, cw);
			cur_cy = track_axis(cur_cy, py, ch);
			dx = cur_cx - emit_x;
			dy = cur_cy - emit_y;
			if (dx * dx + dy * dy > sat(thresh) * sat(thresh)) begin
				r.emit = 1'b1;
				emit_x = cur_cx;
				emit_y = cur_cy;
			end
		end
		r.cx = val_t'(cur_cx);
		r.cy = val_t'(cur_cy);
		r.left = val_t'(clip(cur_cx - (cw >> 1), 0, ONE - cw));
		r.top = val_t'(clip(cur_cy - (ch >> 1), 0, ONE - ch));
		return r;
	endfunction

	// sender
	always @(negedge clk) begin : sender
		cursor_t nxt;
		if (!s_axis_tvalid || s_fire) begin
			if (cursor_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				nxt = cursor_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.mode;
				s_axis_tdata <= S_W'({nxt.py, nxt.px});
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall);
		end
	end

	// monitor and checker
	always @(posedge clk) begin : monitor
		cursor_t seen;
		crop_t got, want;
		s_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CROP_WIDTH: crop_w = cfg_data;
					CFG_CROP_HEIGHT: crop_h = cfg_data;
					CFG_DEAD_ZONE_FRAC: dz_frac = cfg_data;
					CFG_MOVE_THRESHOLD: thresh = cfg_data;
					CFG_CLAMP_CENTER: clamp_on = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.mode = s_axis_tuser;
				seen.px = s_axis_tdata[VW-1:0];
				seen.py = s_axis_tdata[2*VW-1:VW];
				crop_q.push_back(crop_follow(seen));
				accepted++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.cx = m_axis_tdata[VW-1:0];
				got.cy = m_axis_tdata[2*VW-1:VW];
				got.left = m_axis_tdata[3*VW-1:2*VW];
				got.top = m_axis_tdata[4*VW-1:3*VW];
				got.emit = m_axis_tuser;
				if (crop_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transfer at cycle %0d", cycle_cnt);
				end else begin
					want = crop_q.pop_front();
					if (got.cx !== want.cx || got.cy !== want.cy || got.left !== want.left ||
							got.top !== want.top || got.emit !== want.emit) begin
						errors++;
						if (errors <= 10)
							$display("mismatch cycle %0d: exp cx=%0d cy=%0d left=%0d top=%0d emit=%0d, got cx=%0d cy=%0d left=%0d top=%0d emit=%0d",
								cycle_cnt, want.cx, want.cy, want.left, want.top, want.emit,
								got.cx, got.cy, got.left, got.top, got.emit);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_item(logic mode, val_t px, val_t py);
		cursor_t c;
		c.mode = mode;
		c.px = px;
		c.py = py;
		cursor_q.push_back(c);
		issued++;
	endtask

	task automatic write_reg(cfg_idx_t idx, val_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (accepted != issued || crop_q.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	function automatic val_t rand_reg();
		case ($urandom_range(5))
			0: return '0;
			1: return val_t'(ONE);
			2: return val_t'($urandom_range(0, VMAX));
			default: return val_t'($urandom_range(0, ONE));
		endcase
	endfunction

	task automatic add_items(int n);
		repeat (n) begin
			case ($urandom_range(19))
				0, 1: begin
					walk_x = $urandom_range(0, ONE);
					walk_y = $urandom_range(0, ONE);
					push_item(MODE_LOAD, val_t'(walk_x), val_t'(walk_y));
				end
				2: push_item(MODE_LOAD, val_t'($urandom_range(0, VMAX)),
					val_t'($urandom_range(0, VMAX)));
				3, 4, 5: push_item(MODE_TICK, val_t'($urandom_range(0, VMAX)),
					val_t'($urandom_range(0, VMAX)));
				6: push_item(MODE_TICK, $urandom_range(1) ? val_t'(ONE) : '0,
					$urandom_range(1) ? val_t'(ONE) : '0);
				default: begin
					walk_x = clip(walk_x + longint'($urandom_range(0, 6000)) - 3000, 0, ONE);
					walk_y = clip(walk_y + longint'($urandom_range(0, 6000)) - 3000, 0, ONE);
					push_item(MODE_TICK, val_t'(walk_x), val_t'(walk_y));
				end
			endcase
		end
	endtask

	initial begin
		val_t cw, ch, dz, th, cl;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset state and saturation at default registers
		push_item(MODE_TICK, 32768, 32768);
		push_item(MODE_TICK, 0, 0);
		push_item(MODE_TICK, val_t'(VMAX), val_t'(VMAX));
		push_item(MODE_LOAD, 0, val_t'(ONE));
		push_item(MODE_LOAD, val_t'(VMAX), 0);
		settle();
		write_reg(CFG_CROP_WIDTH, 16384);
		write_reg(CFG_CROP_HEIGHT, 8192);
		write_reg(CFG_CLAMP_CENTER, 0);
		push_item(MODE_LOAD, 32768, 32768);
		push_item(MODE_TICK, 32868, 32768);
		push_item(MODE_TICK, 40768, 32768);
		push_item(MODE_TICK, 40868, 32768);
		push_item(MODE_TICK, val_t'(ONE), val_t'(ONE));
		push_item(MODE_TICK, val_t'(VMAX), val_t'(VMAX));
		push_item(MODE_TICK, 0, 0);
		push_item(MODE_TICK, 0, 0);
		push_item(MODE_TICK, 17'h15555, 17'h0AAAA);
		push_item(MODE_TICK, 17'h0AAAA, 17'h15555);
		push_item(MODE_LOAD, 0, 0);
		push_item(MODE_TICK, 0, 0);
		push_item(MODE_LOAD, val_t'(ONE), val_t'(ONE));
		push_item(MODE_TICK, val_t'(ONE), val_t'(ONE));
		settle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin cw = 16384; ch = 32768; dz = 36045; th = 655; cl = 1; end
				1: begin cw = 0; ch = 0; dz = val_t'(ONE); th = 0; cl = 0; end
				2: begin cw = val_t'(VMAX); ch = val_t'(ONE + 1); dz = val_t'(VMAX);
					th = val_t'(VMAX); cl = 1; end
				3: begin cw = 1; ch = val_t'(ONE); dz = 0; th = 1; cl = 0; end
				4: begin cw = val_t'(ONE); ch = 1; dz = 65535; th = 200; cl = 17'h1fffe; end
				default: begin
					cw = rand_reg();
					ch = rand_reg();
					dz = rand_reg();
					th = $urandom_range(3) == 0 ? rand_reg() : val_t'($urandom_range(0, 3000));
					cl = val_t'($urandom_range(0, VMAX));
				end
			endcase
			write_reg(CFG_CROP_WIDTH, cw);
			write_reg(CFG_CROP_HEIGHT, ch);
			write_reg(CFG_DEAD_ZONE_FRAC, dz);
			write_reg(CFG_MOVE_THRESHOLD, th);
			write_reg(CFG_CLAMP_CENTER, cl);
			case (ph % 4)
				0: begin send_idle = 0; rx_stall = 0; end
				1: begin send_idle = 67; rx_stall = 0; end
				2: begin send_idle = 0; rx_stall = 67; end
				default: begin send_idle = 17; rx_stall = 17; end
			endcase
			if (ph == 6) begin
				add_items(PHASE_ITEMS / 2);
				settle();
				add_items(PHASE_ITEMS / 2);
			end else begin
				add_items(PHASE_ITEMS);
				if (ph == 4)
					hold_req = 1'b1;
			end
			settle();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/dzcf_pkg.sv
design/dzcf_cfg.sv
design/dzcf_axis.sv
design/dead_zone_crop_follower_top.sv
tb/dead_zone_crop_follower_top_test.sv
